// File: hw/rtl/gncs_pkg.sv
package gncs_pkg;

	localparam int COORD_BITS_DEF = 4;
	localparam int PC_W = 4;

	localparam logic [7:0] CMD_PING = 8'h57;
	localparam logic [7:0] CMD_PONG = 8'h58;
	localparam logic [7:0] CMD_GO   = 8'h59;
	localparam logic [7:0] CMD_DONE = 8'h5A;

	localparam logic [1:0] ACT_SEND  = 2'd0;
	localparam logic [1:0] ACT_RIGHT = 2'd1;
	localparam logic [1:0] ACT_LEFT  = 2'd2;
	localparam logic [1:0] ACT_STEP  = 2'd3;

	localparam logic [1:0] HEAD_EAST  = 2'd0;
	localparam logic [1:0] HEAD_NORTH = 2'd1;
	localparam logic [1:0] HEAD_WEST  = 2'd2;
	localparam logic [1:0] HEAD_SOUTH = 2'd3;

	// program addresses
	localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
	localparam logic [PC_W-1:0] PC_PING  = 4'd1;
	localparam logic [PC_W-1:0] PC_ECHO  = 4'd2;
	localparam logic [PC_W-1:0] PC_LOADX = 4'd3;
	localparam logic [PC_W-1:0] PC_TURNX = 4'd4;
	localparam logic [PC_W-1:0] PC_STEPX = 4'd5;
	localparam logic [PC_W-1:0] PC_LOADY = 4'd6;
	localparam logic [PC_W-1:0] PC_TURNY = 4'd7;
	localparam logic [PC_W-1:0] PC_STEPY = 4'd8;
	localparam logic [PC_W-1:0] PC_DONE  = 4'd9;

	typedef enum logic [2:0] {
		U_WAIT = 3'd0,
		U_SEND = 3'd1,
		U_LOAD = 3'd2,
		U_TURN = 3'd3,
		U_STEP = 3'd4
	} uop_t;

	typedef enum logic [1:0] {
		SEL_ECHO = 2'd0,
		SEL_PONG = 2'd1,
		SEL_DONE = 2'd2
	} send_t;

	typedef struct packed {
		uop_t            uop;
		logic            axis;
		send_t           send;
		logic [PC_W-1:0] nxt;
	} ctrl_word_t;

	typedef struct packed {
		logic acc;
		logic is_ping;
		logic is_go;
		logic fire;
		logic dist_zero;
		logic rights_zero;
		logic cnt_zero;
	} status_t;

	function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = '{uop: U_WAIT, axis: 1'b0, send: SEL_ECHO, nxt: PC_WAIT};
		unique case (pc)
			PC_WAIT:  w = '{uop: U_WAIT, axis: 1'b0, send: SEL_ECHO, nxt: PC_WAIT};
			PC_PING:  w = '{uop: U_SEND, axis: 1'b0, send: SEL_PONG, nxt: PC_WAIT};
			PC_ECHO:  w = '{uop: U_SEND, axis: 1'b0, send: SEL_ECHO, nxt: PC_WAIT};
			PC_LOADX: w = '{uop: U_LOAD, axis: 1'b0, send: SEL_ECHO, nxt: PC_LOADY};
			PC_TURNX: w = '{uop: U_TURN, axis: 1'b0, send: SEL_ECHO, nxt: PC_STEPX};
			PC_STEPX: w = '{uop: U_STEP, axis: 1'b0, send: SEL_ECHO, nxt: PC_LOADY};
			PC_LOADY: w = '{uop: U_LOAD, axis: 1'b1, send: SEL_ECHO, nxt: PC_DONE};
			PC_TURNY: w = '{uop: U_TURN, axis: 1'b1, send: SEL_ECHO, nxt: PC_STEPY};
			PC_STEPY: w = '{uop: U_STEP, axis: 1'b1, send: SEL_ECHO, nxt: PC_DONE};
			PC_DONE:  w = '{uop: U_SEND, axis: 1'b0, send: SEL_DONE, nxt: PC_WAIT};
			default:  w = '{uop: U_WAIT, axis: 1'b0, send: SEL_ECHO, nxt: PC_WAIT};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/grid_navigation_command_sequencer.sv
// channel  signals                           direction
// -------  --------------------------------  ---------
// in       in_valid, in_stall, rx_byte       receive
// out      out_valid, out_stall, action,     send
//          tx_byte, last
//
// ping and target bytes are accepted, then answered with the reply byte
// a go byte runs, per leg, a load, then the turns, then the steps, and ends with a done byte;
// a zero leg runs only its load; each program step is one word of the control store
// reset puts the program counter at the wait step with position (1,1), facing east
// a stalled result holds the program at its emitting step; input is taken
// only in the wait step, while the last result may still sit in the output register
module grid_navigation_command_sequencer #(
	parameter int COORD_BITS = gncs_pkg::COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] action,
	output logic [7:0] tx_byte,
	output logic       last
);

	gncs_pkg::ctrl_word_t cw;
	gncs_pkg::status_t    st;

	assign in_stall = (cw.uop != gncs_pkg::U_WAIT);

	gncs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cw     (cw)
	);

	gncs_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.in_valid  (in_valid),
		.rx_byte   (rx_byte),
		.out_stall (out_stall),
		.st        (st),
		.out_valid (out_valid),
		.action    (action),
		.tx_byte   (tx_byte),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	a_acc_leaves_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.acc |=> cw.uop != gncs_pkg::U_WAIT)
		else $error("accepted transaction did not start the program");

	a_turns_then_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(cw.uop == gncs_pkg::U_TURN && st.rights_zero) |=> cw.uop == gncs_pkg::U_STEP)
		else $error("turn phase did not hand over to steps");

	a_last_is_send: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> action == gncs_pkg::ACT_SEND)
		else $error("final result of a transaction is not a send");
`endif

endmodule

// File: hw/rtl/gncs_ctrl.sv
module gncs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gncs_pkg::status_t    st,
	output gncs_pkg::ctrl_word_t cw
);

	logic [gncs_pkg::PC_W-1:0] pc_q;
	logic [gncs_pkg::PC_W-1:0] pc_d;
	logic [gncs_pkg::PC_W-1:0] pc_inc;

	assign cw     = gncs_pkg::rom_word(pc_q);
	assign pc_inc = gncs_pkg::PC_W'(pc_q + 1'b1);

	always_comb begin
		pc_d = pc_q;
		unique case (cw.uop)
			gncs_pkg::U_WAIT: begin
				if (st.acc) begin
					priority if (st.is_ping) pc_d = gncs_pkg::PC_PING;
					else if (st.is_go)       pc_d = gncs_pkg::PC_LOADX;
					else                     pc_d = gncs_pkg::PC_ECHO;
				end
			end
			gncs_pkg::U_SEND: if (st.fire) pc_d = cw.nxt;
			// zero distance skips the whole leg
			gncs_pkg::U_LOAD: pc_d = st.dist_zero ? cw.nxt : pc_inc;
			gncs_pkg::U_TURN: if (st.rights_zero) pc_d = pc_inc;
			gncs_pkg::U_STEP: if (st.cnt_zero) pc_d = cw.nxt;
			default:          pc_d = gncs_pkg::PC_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= gncs_pkg::PC_WAIT;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// File: hw/rtl/gncs_datapath.sv
module gncs_datapath #(
	parameter int COORD_BITS = gncs_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gncs_pkg::ctrl_word_t cw,
	input  logic                 in_valid,
	input  logic [7:0]           rx_byte,
	input  logic                 out_stall,
	output gncs_pkg::status_t    st,
	output logic                 out_valid,
	output logic [1:0]           action,
	output logic [7:0]           tx_byte,
	output logic                 last
);

	logic [COORD_BITS-1:0] pos_x_q, pos_y_q, cnt_q;
	logic [1:0]            heading_q, rights_q;
	logic [7:0]            target_q;

	logic                  out_valid_q, last_q;
	logic [1:0]            action_q;
	logic [7:0]            tx_q;

	logic [COORD_BITS-1:0] tgt_x, tgt_y, tgt, cur;
	logic                  up;
	logic [1:0]            want;
	logic                  acc, can_emit, emit, fire, turn_left;
	logic [1:0]            e_act;
	logic [7:0]            e_byte;
	logic                  e_last;

	assign tgt_x = target_q[4 +: COORD_BITS];
	assign tgt_y = target_q[0 +: COORD_BITS];
	assign tgt   = cw.axis ? tgt_y : tgt_x;
	assign cur   = cw.axis ? pos_y_q : pos_x_q;
	assign up    = tgt > cur;
	assign want  = cw.axis ? (up ? gncs_pkg::HEAD_NORTH : gncs_pkg::HEAD_SOUTH)
	                       : (up ? gncs_pkg::HEAD_EAST  : gncs_pkg::HEAD_WEST);

	assign acc       = in_valid && (cw.uop == gncs_pkg::U_WAIT);
	assign can_emit  = !out_valid_q || !out_stall;
	// three rights are done as one left
	assign turn_left = (rights_q == 2'd3);

	always_comb begin
		emit   = 1'b0;
		e_act  = gncs_pkg::ACT_SEND;
		e_byte = 8'd0;
		e_last = 1'b0;
		unique case (cw.uop)
			gncs_pkg::U_SEND: begin
				emit   = 1'b1;
				e_last = 1'b1;
				unique case (cw.send)
					gncs_pkg::SEL_PONG: e_byte = gncs_pkg::CMD_PONG;
					gncs_pkg::SEL_DONE: e_byte = gncs_pkg::CMD_DONE;
					default:            e_byte = target_q;
				endcase
			end
			gncs_pkg::U_TURN: begin
				if (rights_q != 2'd0) begin
					emit  = 1'b1;
					e_act = turn_left ? gncs_pkg::ACT_LEFT : gncs_pkg::ACT_RIGHT;
				end
			end
			gncs_pkg::U_STEP: begin
				if (cnt_q != '0) begin
					emit  = 1'b1;
					e_act = gncs_pkg::ACT_STEP;
				end
			end
			default: ;
		endcase
	end

	assign fire = emit && can_emit;

	assign st.acc         = acc;
	assign st.is_ping     = (rx_byte == gncs_pkg::CMD_PING);
	assign st.is_go       = (rx_byte == gncs_pkg::CMD_GO);
	assign st.fire        = fire;
	assign st.dist_zero   = (tgt == cur);
	assign st.rights_zero = (rights_q == 2'd0);
	assign st.cnt_zero    = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q     <= COORD_BITS'(1);
			pos_y_q     <= COORD_BITS'(1);
			heading_q   <= gncs_pkg::HEAD_EAST;
			target_q    <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc && !st.is_ping && !st.is_go) target_q <= rx_byte;
			if (cw.uop == gncs_pkg::U_LOAD) begin
				if (cw.axis) pos_y_q <= tgt;
				else         pos_x_q <= tgt;
			end
			if (fire && cw.uop == gncs_pkg::U_TURN) begin
				heading_q <= turn_left ? 2'(heading_q + 2'd1) : 2'(heading_q + 2'd3);
			end
			if (fire)           out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.uop == gncs_pkg::U_LOAD) begin
			rights_q <= 2'(heading_q - want);
			cnt_q    <= up ? COORD_BITS'(tgt - cur) : COORD_BITS'(cur - tgt);
		end else if (fire && cw.uop == gncs_pkg::U_TURN) begin
			rights_q <= turn_left ? 2'd0 : 2'(rights_q - 2'd1);
		end else if (fire && cw.uop == gncs_pkg::U_STEP) begin
			cnt_q <= COORD_BITS'(cnt_q - 1'b1);
		end
		if (fire) begin
			action_q <= e_act;
			tx_q     <= e_byte;
			last_q   <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign tx_byte   = tx_q;
	assign last      = last_q;

endmodule
